@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the calculator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold on the next clock edge
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold on the same clock edge
`define ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/fpck_pkg.sv @@
// ---------------------------------------------------------------------------
// fpck_pkg
// Key codes, operator codes and fixed point constants of the calculator.
// ---------------------------------------------------------------------------
package fpck_pkg;

    typedef logic [63:0] word_t;

    // Key codes
    localparam logic [3:0] OP_DIGIT = 4'd0;
    localparam logic [3:0] OP_POINT = 4'd1;
    localparam logic [3:0] OP_CLEAR = 4'd2;
    localparam logic [3:0] OP_BKSP  = 4'd3;
    localparam logic [3:0] OP_SQR   = 4'd4;
    localparam logic [3:0] OP_ROOT  = 4'd5;
    localparam logic [3:0] OP_EQ    = 4'd6;
    localparam logic [3:0] OP_ADD   = 4'd7;
    localparam logic [3:0] OP_SUB   = 4'd8;
    localparam logic [3:0] OP_MUL   = 4'd9;
    localparam logic [3:0] OP_DIV   = 4'd10;

    // Pending operator codes
    localparam logic [2:0] PEND_NONE = 3'd0;
    localparam logic [2:0] PEND_ADD  = 3'd1;
    localparam logic [2:0] PEND_SUB  = 3'd2;
    localparam logic [2:0] PEND_MUL  = 3'd3;
    localparam logic [2:0] PEND_DIV  = 3'd4;

    // Fixed point constants
    localparam word_t SCALE      = 64'd1000000;
    localparam word_t ROOT_SCALE = 64'd1000;
    localparam word_t TEN        = 64'd10;

    // Last fraction digit position that still counts
    localparam logic [2:0] FRAC_LAST = 3'd6;

    // Integer digit scaled to fixed point
    function automatic logic [23:0] digit_scaled(input logic [3:0] d);
        digit_scaled = 24'(d) * 24'd1000000;
    endfunction

    // Fraction digit at position k (1..6) scaled to fixed point
    function automatic logic [23:0] digit_part(input logic [3:0] d, input logic [2:0] k);
        logic [23:0] w;
        case (k)
            3'd1:    w = 24'd100000;
            3'd2:    w = 24'd10000;
            3'd3:    w = 24'd1000;
            3'd4:    w = 24'd100;
            3'd5:    w = 24'd10;
            3'd6:    w = 24'd1;
            default: w = 24'd0;
        endcase
        digit_part = 24'(d) * w;
    endfunction

endpackage

@@ hdl/fixed_point_calculator_keys.sv @@
// ---------------------------------------------------------------------------
// fixed_point_calculator_keys
// Key-driven four-function calculator in signed fixed point (scale 1e6).
// ---------------------------------------------------------------------------
// Most keys go straight to finishing; an integer digit adds a digit step,
// backspace uses the divider, square or a folded multiply or divide uses the
// multiplier then the divider; root loops divider steps, then scales by 1000.
// One item at a time; the next key is taken while the last result waits.
// Reset: asynchronous, active low; value and accumulator clear, new entry set.
module fixed_point_calculator_keys
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] digit_value, [7:4] zero
    input  logic [3:0]  s_tuser,   // [3:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] display_value
    output logic [0:0]  m_tuser    // [0] error_shown
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIG   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_RCMP  = 3'd4;
    localparam logic [2:0] S_RSTEP = 3'd5;
    localparam logic [2:0] S_RCHK  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    localparam logic [1:0] D_ENT  = 2'd0;
    localparam logic [1:0] D_ACC  = 2'd1;
    localparam logic [1:0] D_BOTH = 2'd2;

    logic [2:0]      state_reg, state_next;
    fpck_pkg::word_t acc_reg, acc_next;
    fpck_pkg::word_t ent_reg, ent_next;
    logic [2:0]      pend_reg, pend_next;
    logic            nef_reg, nef_next;
    logic            err_reg, err_next;
    logic            frac_reg, frac_next;
    logic [2:0]      fexp_reg, fexp_next;
    logic            root_reg, root_next;
    logic            rfin_reg, rfin_next;
    logic [1:0]      dest_reg, dest_next;
    logic            ov_reg, ov_next;
    logic            mst_reg, mst_next;
    logic            dst_reg, dst_next;

    fpck_pkg::word_t tmp_reg, tmp_next;
    fpck_pkg::word_t rx_reg, rx_next;
    fpck_pkg::word_t ry_reg, ry_next;
    fpck_pkg::word_t divb_reg, divb_next;
    fpck_pkg::word_t ma_reg, ma_next;
    fpck_pkg::word_t mb_reg, mb_next;
    fpck_pkg::word_t da_reg, da_next;
    fpck_pkg::word_t db_reg, db_next;
    logic [3:0]      dig_reg, dig_next;
    fpck_pkg::word_t od_reg, od_next;
    logic            oe_reg, oe_next;

    logic            mul_done, div_done;
    fpck_pkg::word_t prod, quot;

    fpck_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mst_reg),
        .a       (ma_reg),
        .b       (mb_reg),
        .done    (mul_done),
        .product (prod)
    );

    fpck_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dst_reg),
        .a     (da_reg),
        .b     (db_reg),
        .done  (div_done),
        .quot  (quot)
    );

    assign s_tready = (state_reg == S_IDLE);

    // Key decode and sequencing
    always_comb
    begin
        logic [3:0]      op;
        logic [3:0]      d;
        logic            both;
        logic            do_apply;
        fpck_pkg::word_t sum;
        fpck_pkg::word_t part;
        fpck_pkg::word_t dsc;

        op   = s_tuser;
        d    = s_tdata[3:0];
        both = 1'b0;
        do_apply = 1'b0;
        sum  = '0;
        part = 64'(fpck_pkg::digit_part(d, fexp_reg));
        dsc  = 64'(fpck_pkg::digit_scaled(dig_reg));

        state_next = state_reg;
        acc_next   = acc_reg;
        ent_next   = ent_reg;
        pend_next  = pend_reg;
        nef_next   = nef_reg;
        err_next   = err_reg;
        frac_next  = frac_reg;
        fexp_next  = fexp_reg;
        root_next  = root_reg;
        rfin_next  = rfin_reg;
        dest_next  = dest_reg;
        ov_next    = ov_reg && !m_tready;
        mst_next   = 1'b0;
        dst_next   = 1'b0;
        tmp_next   = tmp_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        divb_next  = divb_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        dig_next   = dig_reg;
        od_next    = od_reg;
        oe_next    = oe_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_FIN;
                    rfin_next  = 1'b0;
                    case (op)
                        fpck_pkg::OP_DIGIT:
                        begin
                            err_next = 1'b0;
                            if (nef_reg || err_reg)
                            begin
                                ent_next  = 64'(fpck_pkg::digit_scaled(d));
                                nef_next  = 1'b0;
                                frac_next = 1'b0;
                            end
                            else if (frac_reg)
                            begin
                                if (fexp_reg <= fpck_pkg::FRAC_LAST)
                                begin
                                    ent_next  = ent_reg[63] ? (ent_reg - part)
                                                            : (ent_reg + part);
                                    fexp_next = fexp_reg + 3'd1;
                                end
                            end
                            else
                            begin
                                tmp_next   = {ent_reg[60:0], 3'b000} + {ent_reg[62:0], 1'b0};
                                dig_next   = d;
                                state_next = S_DIG;
                            end
                        end
                        fpck_pkg::OP_POINT:
                        begin
                            if (nef_reg)
                            begin
                                ent_next = '0;
                                nef_next = 1'b0;
                            end
                            if (!frac_reg)
                            begin
                                frac_next = 1'b1;
                                fexp_next = 3'd1;
                            end
                        end
                        fpck_pkg::OP_CLEAR:
                        begin
                            ent_next  = '0;
                            acc_next  = '0;
                            pend_next = fpck_pkg::PEND_NONE;
                            nef_next  = 1'b1;
                            err_next  = 1'b0;
                            frac_next = 1'b0;
                        end
                        fpck_pkg::OP_BKSP:
                        begin
                            if (!nef_reg && !err_reg)
                            begin
                                if (frac_reg)
                                begin
                                    ent_next = '0;
                                    nef_next = 1'b1;
                                end
                                else
                                begin
                                    da_next    = ent_reg;
                                    db_next    = fpck_pkg::TEN;
                                    dst_next   = 1'b1;
                                    dest_next  = D_ENT;
                                    state_next = S_DIV;
                                end
                            end
                        end
                        fpck_pkg::OP_SQR:
                        begin
                            nef_next   = 1'b1;
                            ma_next    = ent_reg;
                            mb_next    = ent_reg;
                            mst_next   = 1'b1;
                            divb_next  = fpck_pkg::SCALE;
                            dest_next  = D_ENT;
                            state_next = S_MUL;
                        end
                        fpck_pkg::OP_ROOT:
                        begin
                            nef_next = 1'b1;
                            if (ent_reg[63])
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                rx_next    = ent_reg;
                                ry_next    = 64'd1;
                                root_next  = 1'b1;
                                state_next = S_RCMP;
                            end
                        end
                        fpck_pkg::OP_EQ:
                        begin
                            pend_next = fpck_pkg::PEND_NONE;
                            nef_next  = 1'b1;
                            frac_next = 1'b0;
                            both      = 1'b1;
                            do_apply  = 1'b1;
                        end
                        fpck_pkg::OP_ADD, fpck_pkg::OP_SUB,
                        fpck_pkg::OP_MUL, fpck_pkg::OP_DIV:
                        begin
                            if (!nef_reg)
                            begin
                                if (pend_reg != fpck_pkg::PEND_NONE)
                                begin
                                    do_apply = 1'b1;
                                end
                                else
                                begin
                                    acc_next = ent_reg;
                                end
                            end
                            pend_next = 3'(op - fpck_pkg::OP_EQ);
                            nef_next  = 1'b1;
                            frac_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase

                    // Fold the pending operator into the accumulator
                    if (do_apply)
                    begin
                        dest_next = both ? D_BOTH : D_ACC;
                        case (pend_reg)
                            fpck_pkg::PEND_ADD, fpck_pkg::PEND_SUB:
                            begin
                                sum = (pend_reg == fpck_pkg::PEND_ADD) ? (acc_reg + ent_reg)
                                                                       : (acc_reg - ent_reg);
                                acc_next = sum;
                                if (both)
                                begin
                                    ent_next = sum;
                                end
                            end
                            fpck_pkg::PEND_MUL:
                            begin
                                ma_next    = acc_reg;
                                mb_next    = ent_reg;
                                mst_next   = 1'b1;
                                divb_next  = fpck_pkg::SCALE;
                                state_next = S_MUL;
                            end
                            fpck_pkg::PEND_DIV:
                            begin
                                if (ent_reg == '0)
                                begin
                                    err_next = 1'b1;
                                    if (both)
                                    begin
                                        ent_next = acc_reg;
                                    end
                                end
                                else
                                begin
                                    ma_next    = acc_reg;
                                    mb_next    = fpck_pkg::SCALE;
                                    mst_next   = 1'b1;
                                    divb_next  = ent_reg;
                                    state_next = S_MUL;
                                end
                            end
                            default:
                            begin
                                acc_next = ent_reg;
                            end
                        endcase
                    end
                end
            end
            // Integer digit: value times ten plus or minus the digit
            S_DIG:
            begin
                ent_next   = ent_reg[63] ? (tmp_reg - dsc) : (tmp_reg + dsc);
                state_next = S_FIN;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    if (rfin_reg)
                    begin
                        ent_next   = prod;
                        rfin_next  = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        da_next    = prod;
                        db_next    = divb_reg;
                        dst_next   = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (root_reg)
                    begin
                        ry_next    = quot;
                        state_next = S_RCMP;
                    end
                    else
                    begin
                        case (dest_reg)
                            D_ACC:
                            begin
                                acc_next = quot;
                            end
                            D_BOTH:
                            begin
                                acc_next = quot;
                                ent_next = quot;
                            end
                            default:
                            begin
                                ent_next = quot;
                            end
                        endcase
                        state_next = S_FIN;
                    end
                end
            end
            // Babylonian root: loop while x > y, then scale by 1000
            S_RCMP:
            begin
                if (rx_reg > ry_reg)
                begin
                    state_next = S_RSTEP;
                end
                else
                begin
                    root_next  = 1'b0;
                    ma_next    = rx_reg;
                    mb_next    = fpck_pkg::ROOT_SCALE;
                    mst_next   = 1'b1;
                    rfin_next  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_RSTEP:
            begin
                rx_next = {1'b0, rx_reg[63:1]} + {1'b0, ry_reg[63:1]}
                        + {63'd0, rx_reg[0] & ry_reg[0]};
                state_next = S_RCHK;
            end
            S_RCHK:
            begin
                if (rx_reg == '0)
                begin
                    ent_next   = '0;
                    root_next  = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    da_next    = ent_reg;
                    db_next    = rx_reg;
                    dst_next   = 1'b1;
                    state_next = S_DIV;
                end
            end
            // Hand the result to the output register once it is free
            S_FIN:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = ent_reg;
                    oe_next    = err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
            ent_reg   <= '0;
            pend_reg  <= fpck_pkg::PEND_NONE;
            nef_reg   <= 1'b1;
            err_reg   <= 1'b0;
            frac_reg  <= 1'b0;
            fexp_reg  <= 3'd1;
            root_reg  <= 1'b0;
            rfin_reg  <= 1'b0;
            dest_reg  <= D_ENT;
            ov_reg    <= 1'b0;
            mst_reg   <= 1'b0;
            dst_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            ent_reg   <= ent_next;
            pend_reg  <= pend_next;
            nef_reg   <= nef_next;
            err_reg   <= err_next;
            frac_reg  <= frac_next;
            fexp_reg  <= fexp_next;
            root_reg  <= root_next;
            rfin_reg  <= rfin_next;
            dest_reg  <= dest_next;
            ov_reg    <= ov_next;
            mst_reg   <= mst_next;
            dst_reg   <= dst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg  <= tmp_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        divb_reg <= divb_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        da_reg   <= da_next;
        db_reg   <= db_next;
        dig_reg  <= dig_next;
        od_reg   <= od_next;
        oe_reg   <= oe_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = oe_reg;

endmodule

@@ hdl/fpck_mul.sv @@
// ---------------------------------------------------------------------------
// fpck_mul
// Bit-serial shift-add multiplier, low 64 bits of the product.
// ---------------------------------------------------------------------------
module fpck_mul
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  fpck_pkg::word_t a,
    input  fpck_pkg::word_t b,
    output logic           done,
    output fpck_pkg::word_t product
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [5:0]      cnt_reg, cnt_next;
    fpck_pkg::word_t a_reg, a_next;
    fpck_pkg::word_t b_reg, b_next;
    fpck_pkg::word_t p_reg, p_next;

    // One multiplier bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                a_next    = a;
                b_next    = b;
                p_next    = '0;
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end
        else
        begin
            if (b_reg[0])
            begin
                p_next = p_reg + a_reg;
            end
            a_next   = {a_reg[62:0], 1'b0};
            b_next   = {1'b0, b_reg[63:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

@@ hdl/fpck_div.sv @@
// ---------------------------------------------------------------------------
// fpck_div
// Bit-serial signed divider, truncating toward zero; a start is taken only when idle.
// ---------------------------------------------------------------------------
module fpck_div
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  fpck_pkg::word_t a,
    input  fpck_pkg::word_t b,
    output logic           done,
    output fpck_pkg::word_t quot
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_RUN  = 2'd1;
    localparam logic [1:0] P_FIX  = 2'd2;

    logic [1:0]      phase_reg, phase_next;
    logic            done_reg, done_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            neg_reg, neg_next;
    fpck_pkg::word_t q_reg, q_next;
    fpck_pkg::word_t rem_reg, rem_next;
    fpck_pkg::word_t mb_reg, mb_next;
    logic [64:0]     r2;

    // Magnitudes in, one quotient bit a cycle, sign fixed at the end
    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        mb_next    = mb_reg;
        r2         = {rem_reg, q_reg[63]};
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    neg_next   = a[63] ^ b[63];
                    q_next     = a[63] ? (64'd0 - a) : a;
                    mb_next    = b[63] ? (64'd0 - b) : b;
                    rem_next   = '0;
                    cnt_next   = '0;
                    phase_next = P_RUN;
                end
            end
            P_RUN:
            begin
                if (r2 >= {1'b0, mb_reg})
                begin
                    rem_next = 64'(r2 - {1'b0, mb_reg});
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = r2[63:0];
                    q_next   = {q_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    phase_next = P_FIX;
                end
            end
            P_FIX:
            begin
                if (neg_reg)
                begin
                    q_next = 64'd0 - q_reg;
                end
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        mb_reg  <= mb_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ hdl/fpck_check.sv @@
// ---------------------------------------------------------------------------
// fpck_check
// Port-level checks of the calculator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fpck_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // One key at a time: ready drops after each accepted item
    `ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "ready held after accept")

    // A new result appears only as the sequencer leaves its work
    `ASSERT_SAME(a_result_src, $rose(m_tvalid), $past(!s_tready), "result without work")

    // Stalled result holds its value
    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser),
        "stalled result changed")

endmodule

bind fixed_point_calculator_keys fpck_check u_fpck_check (.*);

@@ test/fpck_checker.sv @@
// ---------------------------------------------------------------------------
// fpck_checker
// Watches both item channels of the key calculator, tracks its own copy of
// the calculator state and compares every displayed value and error flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpck_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [63:0] shown;
        logic        err;
    } display_t;

    // calculator state as tracked here
    fpck_pkg::word_t acc;
    fpck_pkg::word_t entry;
    logic [2:0]      pend_op;
    logic            fresh;
    logic            err_flag;
    logic            in_frac;
    logic [23:0]     frac_div;

    display_t        shown_q[$];

    function automatic fpck_pkg::word_t signed_quot(input fpck_pkg::word_t a,
                                                    input fpck_pkg::word_t b);
        fpck_pkg::word_t ma;
        fpck_pkg::word_t mb;
        fpck_pkg::word_t q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        if (mb == 0)
            return 0;
        q = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    // Babylonian integer root, sum taken without overflow
    function automatic fpck_pkg::word_t babylon_root(input fpck_pkg::word_t n);
        fpck_pkg::word_t x;
        fpck_pkg::word_t y;
        x = n;
        y = 1;
        if (n == 0)
            return 0;
        while (x > y)
        begin
            x = (x >> 1) + (y >> 1) + (x & y & 64'd1);
            if (x == 0)
                break;
            y = n / x;
        end
        return x;
    endfunction

    task automatic fold_pending();
        case (pend_op)
            fpck_pkg::PEND_ADD: acc = acc + entry;
            fpck_pkg::PEND_SUB: acc = acc - entry;
            fpck_pkg::PEND_MUL: acc = signed_quot(acc * entry, fpck_pkg::SCALE);
            fpck_pkg::PEND_DIV:
            begin
                if (entry == 0)
                    err_flag = 1'b1;
                else
                    acc = signed_quot(acc * fpck_pkg::SCALE, entry);
            end
            default:  acc = entry;
        endcase
    endtask

    // advance the tracked state by one key press
    task automatic press_key(input logic [3:0] key, input logic [3:0] dig);
        fpck_pkg::word_t d;
        fpck_pkg::word_t part;
        d = 64'(dig);
        case (key)
            fpck_pkg::OP_DIGIT:
            begin
                if (fresh || err_flag)
                begin
                    entry   = d * fpck_pkg::SCALE;
                    fresh   = 1'b0;
                    in_frac = 1'b0;
                end
                else if (in_frac)
                begin
                    if (frac_div != 0 && 64'(frac_div) <= fpck_pkg::SCALE)
                    begin
                        part = (d * fpck_pkg::SCALE) / 64'(frac_div);
                        entry = entry[63] ? entry - part : entry + part;
                        frac_div = 24'(frac_div * 10);
                    end
                end
                else
                    entry = entry[63] ? entry * fpck_pkg::TEN - d * fpck_pkg::SCALE
                                      : entry * fpck_pkg::TEN + d * fpck_pkg::SCALE;
                err_flag = 1'b0;
            end
            fpck_pkg::OP_POINT:
            begin
                if (fresh)
                begin
                    entry = 0;
                    fresh = 1'b0;
                end
                if (!in_frac)
                begin
                    in_frac  = 1'b1;
                    frac_div = 24'd10;
                end
            end
            fpck_pkg::OP_CLEAR:
            begin
                entry    = 0;
                acc      = 0;
                pend_op  = fpck_pkg::PEND_NONE;
                fresh    = 1'b1;
                err_flag = 1'b0;
                in_frac  = 1'b0;
            end
            fpck_pkg::OP_BKSP:
            begin
                if (!fresh && !err_flag)
                begin
                    if (in_frac)
                    begin
                        entry = 0;
                        fresh = 1'b1;
                    end
                    else
                        entry = signed_quot(entry, fpck_pkg::TEN);
                end
            end
            fpck_pkg::OP_SQR:
            begin
                entry = signed_quot(entry * entry, fpck_pkg::SCALE);
                fresh = 1'b1;
            end
            fpck_pkg::OP_ROOT:
            begin
                if (entry[63])
                    err_flag = 1'b1;
                else
                    entry = babylon_root(entry) * fpck_pkg::ROOT_SCALE;
                fresh = 1'b1;
            end
            fpck_pkg::OP_EQ:
            begin
                fold_pending();
                entry   = acc;
                pend_op = fpck_pkg::PEND_NONE;
                fresh   = 1'b1;
                in_frac = 1'b0;
            end
            fpck_pkg::OP_ADD, fpck_pkg::OP_SUB, fpck_pkg::OP_MUL, fpck_pkg::OP_DIV:
            begin
                if (!fresh)
                begin
                    if (pend_op != fpck_pkg::PEND_NONE)
                        fold_pending();
                    else
                        acc = entry;
                end
                pend_op = 3'(key - fpck_pkg::OP_EQ);
                fresh   = 1'b1;
                in_frac = 1'b0;
            end
            default: ;
        endcase
    endtask

    assign pending = shown_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        display_t want;
        if (!rst_n)
        begin
            acc        = 0;
            entry      = 0;
            pend_op    = fpck_pkg::PEND_NONE;
            fresh      = 1'b1;
            err_flag   = 1'b0;
            in_frac    = 1'b0;
            frac_div   = 24'd10;
            fail_count = 0;
            shown_q.delete();
        end
        else
        begin
            // result side first: a key taken now cannot be answered this edge
            if (m_tvalid && m_tready)
            begin
                if (shown_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result value=%h err=%b",
                                 $realtime, m_tdata, m_tuser);
                end
                else
                begin
                    want = shown_q.pop_front();
                    if (want.shown !== m_tdata || want.err !== m_tuser[0])
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch value exp=%h got=%h err exp=%b got=%b",
                                     $realtime, want.shown, m_tdata, want.err, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                press_key(s_tuser, s_tdata[3:0]);
                want.shown = entry;
                want.err   = err_flag;
                shown_q.push_back(want);
            end
        end
    end

endmodule

@@ test/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives key presses into the fixed point calculator: a directed opening,
// then random well-formed calculations with some noise, under three idling
// patterns. The checker compares every result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [3:0] digit_value, [7:4] zero
    logic [3:0]  s_tuser;   // [3:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] display_value
    logic [0:0]  m_tuser;   // [0] error_shown

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int keys_sent;

    fixed_point_calculator_keys DUT (.*);

    fpck_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls at the set rate
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    initial
    begin
        #100ms;
        $display("testbench failed");
        $finish;
    end

    task automatic send_key(input logic [3:0] key, input logic [3:0] dig);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= key;
        s_tdata  <= {4'd0, dig};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        keys_sent++;
    endtask

    task automatic send_digits(input int count);
        repeat (count)
            send_key(fpck_pkg::OP_DIGIT, ($urandom_range(19) == 0) ? 4'($urandom_range(15))
                                                                    : 4'($urandom_range(9)));
    endtask

    // one operand: integer digits, maybe a fraction running past six digits
    task automatic send_number();
        send_digits($urandom_range(1, 5));
        if ($urandom_range(2) == 0)
        begin
            send_key(fpck_pkg::OP_POINT, 4'($urandom));
            send_digits($urandom_range(1, 8));
        end
        if ($urandom_range(9) == 0)
            send_key(fpck_pkg::OP_BKSP, 4'($urandom));
    endtask

    task automatic send_calculation();
        logic [3:0] key;
        send_number();
        repeat ($urandom_range(1, 3))
        begin
            key = 4'($urandom_range(fpck_pkg::OP_ADD, fpck_pkg::OP_DIV));
            send_key(key, 4'($urandom));
            if (key == fpck_pkg::OP_DIV && $urandom_range(5) == 0)
                send_key(fpck_pkg::OP_DIGIT, 4'd0);
            else
                send_number();
        end
        case ($urandom_range(5))
            0: send_key(fpck_pkg::OP_SQR, 4'($urandom));
            1: send_key(fpck_pkg::OP_ROOT, 4'($urandom));
            default: ;
        endcase
        send_key(fpck_pkg::OP_EQ, 4'($urandom));
        if ($urandom_range(3) == 0)
            send_key(4'($urandom_range(fpck_pkg::OP_SQR, fpck_pkg::OP_ROOT)), 4'($urandom));
        if ($urandom_range(4) == 0)
            send_key(fpck_pkg::OP_CLEAR, 4'($urandom));
    endtask

    initial
    begin
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 48;
        keys_sent     = 0;
        rst_n         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: digits above nine, fraction past six digits, backspace
        send_key(fpck_pkg::OP_DIGIT, 4'd15);
        send_key(fpck_pkg::OP_DIGIT, 4'd9);
        send_key(fpck_pkg::OP_BKSP, 4'd0);
        send_key(fpck_pkg::OP_POINT, 4'd0);
        send_digits(8);
        send_key(fpck_pkg::OP_BKSP, 4'd0);
        // negative value and its root, then square and root of a new digit
        send_key(fpck_pkg::OP_SUB, 4'd0);
        send_key(fpck_pkg::OP_DIGIT, 4'd7);
        send_key(fpck_pkg::OP_EQ, 4'd0);
        send_key(fpck_pkg::OP_ROOT, 4'd0);
        send_key(fpck_pkg::OP_DIGIT, 4'd2);
        send_key(fpck_pkg::OP_SQR, 4'd0);
        send_key(fpck_pkg::OP_ROOT, 4'd0);
        // division by zero, multiply, unused key codes
        send_key(fpck_pkg::OP_DIV, 4'd0);
        send_key(fpck_pkg::OP_DIGIT, 4'd0);
        send_key(fpck_pkg::OP_EQ, 4'd0);
        send_key(fpck_pkg::OP_MUL, 4'd0);
        send_key(fpck_pkg::OP_DIGIT, 4'd3);
        send_key(fpck_pkg::OP_EQ, 4'd0);
        for (int k = 11; k < 16; k++)
            send_key(4'(k), 4'($urandom));
        send_key(fpck_pkg::OP_CLEAR, 4'd0);

        // random part in three idling phases
        while (keys_sent < 940)
        begin
            if (keys_sent > 630)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (keys_sent > 320)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 8;
            end
            if ($urandom_range(7) == 0)
                send_key(4'($urandom), 4'($urandom));
            else
                send_calculation();
        end
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
